// ----- hdl/local_alignment_score_assert.svh -----
// Assertion helpers used by the top-level RTL module.
`ifndef LOCAL_ALIGNMENT_SCORE_ASSERT_SVH
`define LOCAL_ALIGNMENT_SCORE_ASSERT_SVH

// The antecedent holds, so the consequent holds in the same cycle.
`define LAS_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");

// The antecedent holds, so the consequent holds in the next cycle.
`define LAS_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

// The expression holds at every clock edge outside reset.
`define LAS_ASSERT_ALW(label, clk, rst, a) \
  label: assert property (@(posedge clk) disable iff (rst) (a)) \
    else $error("assertion failed: invariant");

`endif

// ----- hdl/las_pkg.sv -----
package las_pkg;

  typedef logic [11:0] h_t;
  typedef logic signed [12:0] sc_t;
  typedef logic signed [13:0] wide_t;

  localparam wide_t H_CLAMP = 14'sd4092;
  localparam sc_t OUT_SAT = 13'sd1023;
  localparam sc_t BEST_NONE = -13'sd1;

  localparam logic [1:0] REG_MATCH = 2'd0;
  localparam logic [1:0] REG_MISMATCH = 2'd1;
  localparam logic [1:0] REG_GAP = 2'd2;

  typedef struct packed {
    logic [3:0] match_score;
    logic signed [4:0] mismatch_score;
    logic [3:0] gap_penalty;
  } cfg_t;

  typedef struct packed {
    logic active;
    logic load;
    logic clear;
  } cell_ctl_t;

  typedef struct packed {
    logic tok;
    logic [7:0] base;
    h_t up_h;
    sc_t up_ix;
    h_t diag;
    sc_t best;
  } chain_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  function automatic wide_t smax(input wide_t a, input wide_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ----- hdl/local_alignment_score.sv -----
// Smith-Waterman local alignment score with linear gaps.
// Input stream: s_tdata carries the base, s_tuser selects a query base (0) or a
// reference base (1), and s_tlast marks the final base of a query or window.
// Query bases are stored one per cell of a row of QUERY_MAX cells. A reference
// base sends a token down the cell row, one cell per cycle, and no further item
// is accepted until the token has left the last cell and the block is idle again.
// On a reference base with s_tlast set, the best score of the window appears on
// m_tdata once the token has left the last cell.
// The output register holds one result; query bases are still accepted while
// it waits. A window end that finds the register full waits until the receiver
// takes the pending result, and no input is accepted during that wait.
// Reset clears the query, the column state and the best score, and restores
// the scoring registers to match 2, mismatch -1 and gap 1. The user must write
// the APB port only while the block is idle; the block does not enforce this.
`include "local_alignment_score_assert.svh"

module local_alignment_score #(
  parameter int QUERY_MAX = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] base
  input  logic        s_tuser,  // [0] action
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // [10:0] best_score, [15:11] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LW = $clog2(QUERY_MAX + 1);

  las_pkg::cfg_t cfg;
  las_pkg::state_t state;
  las_pkg::state_t state_next;
  logic [LW-1:0] qlen;
  logic qopen;
  las_pkg::sc_t best;
  logic ref_last;
  las_pkg::chain_t head;
  logic [10:0] out_score;
  las_pkg::sc_t chain_best;

  logic accept;
  logic q_acc;
  logic r_acc;
  logic [LW-1:0] widx;
  logic fits;
  logic finish_go;
  logic clear_win;

  las_pkg::chain_t chain [QUERY_MAX+1];
  logic [QUERY_MAX:0] tok_vec;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_score <= 4'd2;
      cfg.mismatch_score <= -5'sd1;
      cfg.gap_penalty <= 4'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        las_pkg::REG_MATCH: cfg.match_score <= pwdata[3:0];
        las_pkg::REG_MISMATCH: cfg.mismatch_score <= $signed(pwdata[4:0]);
        las_pkg::REG_GAP: cfg.gap_penalty <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      las_pkg::REG_MATCH: prdata = {28'd0, cfg.match_score};
      las_pkg::REG_MISMATCH: prdata = {{27{cfg.mismatch_score[4]}}, cfg.mismatch_score};
      las_pkg::REG_GAP: prdata = {28'd0, cfg.gap_penalty};
      default: prdata = '0;
    endcase
  end

  assign s_tready = (state == las_pkg::ST_IDLE);
  assign accept = s_tvalid && s_tready;
  assign q_acc = accept && !s_tuser;
  assign r_acc = accept && s_tuser;
  assign widx = qopen ? qlen : '0;
  assign fits = (widx < LW'(QUERY_MAX));
  assign chain_best = chain[QUERY_MAX].best;
  assign clear_win = q_acc || (finish_go && ref_last);

  always_comb begin
    state_next = state;
    finish_go = 1'b0;
    case (state)
      las_pkg::ST_IDLE: begin
        if (r_acc) begin
          state_next = las_pkg::ST_RUN;
        end
      end
      las_pkg::ST_RUN: begin
        if (chain[QUERY_MAX].tok) begin
          state_next = las_pkg::ST_FINISH;
        end
      end
      las_pkg::ST_FINISH: begin
        if (!ref_last || !m_tvalid || m_tready) begin
          finish_go = 1'b1;
          state_next = las_pkg::ST_IDLE;
        end
      end
      default: state_next = las_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= las_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qlen <= '0;
      qopen <= 1'b0;
    end else if (q_acc) begin
      qlen <= widx + (fits ? LW'(1) : LW'(0));
      qopen <= !s_tlast;
    end else if (r_acc) begin
      qopen <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best <= las_pkg::BEST_NONE;
    end else if (clear_win) begin
      best <= las_pkg::BEST_NONE;
    end else if (finish_go) begin
      best <= chain_best;
    end
  end

  always_ff @(posedge clk) begin
    if (r_acc) begin
      ref_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head.tok <= 1'b0;
    end else begin
      head.tok <= r_acc;
    end
    if (r_acc) begin
      head.base <= s_tdata;
      head.up_h <= '0;
      head.up_ix <= '0;
      head.diag <= '0;
      head.best <= best;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish_go && ref_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go && ref_last) begin
      out_score <= (chain_best > las_pkg::OUT_SAT) ? las_pkg::OUT_SAT[10:0] : chain_best[10:0];
    end
  end

  assign m_tdata = {5'd0, out_score};

  assign chain[0] = head;

  for (genvar g = 0; g < QUERY_MAX; g++) begin : g_cell
    las_pkg::cell_ctl_t ctl;
    assign ctl.active = (LW'(g) < qlen);
    assign ctl.load = q_acc && fits && (widx == LW'(g));
    assign ctl.clear = clear_win;

    las_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cfg       (cfg),
      .ctl       (ctl),
      .load_base (s_tdata),
      .prev      (chain[g]),
      .next      (chain[g+1])
    );
  end

  for (genvar g = 0; g <= QUERY_MAX; g++) begin : g_tok
    assign tok_vec[g] = chain[g].tok;
  end

  `LAS_ASSERT_ALW(a_one_token, clk, rst, $onehot0(tok_vec))
  `LAS_ASSERT_IMP(a_exit_in_run, clk, rst, chain[QUERY_MAX].tok, state == las_pkg::ST_RUN)
  `LAS_ASSERT_NXT(a_ref_starts_chain, clk, rst, r_acc, head.tok && state == las_pkg::ST_RUN)
  `LAS_ASSERT_IMP(a_result_from_finish, clk, rst, $rose(m_tvalid),
                  $past(state) == las_pkg::ST_FINISH)

endmodule

// ----- hdl/las_cell.sv -----
module las_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  las_pkg::cfg_t        cfg,
  input  las_pkg::cell_ctl_t   ctl,
  input  logic [7:0]           load_base,
  input  las_pkg::chain_t      prev,
  output las_pkg::chain_t      next
);

  logic [7:0] qbase;
  las_pkg::h_t h;
  las_pkg::sc_t iy;
  las_pkg::chain_t out_reg;

  las_pkg::wide_t up_h_w;
  las_pkg::wide_t up_ix_w;
  las_pkg::wide_t h_w;
  las_pkg::wide_t iy_w;
  las_pkg::wide_t gap_w;
  las_pkg::wide_t sc_w;
  las_pkg::wide_t ix_new;
  las_pkg::wide_t iy_new;
  las_pkg::wide_t d_new;
  las_pkg::wide_t h_new;
  las_pkg::wide_t best_w;

  always_comb begin
    up_h_w = $signed({2'b00, prev.up_h});
    up_ix_w = $signed({prev.up_ix[12], prev.up_ix});
    h_w = $signed({2'b00, h});
    iy_w = $signed({iy[12], iy});
    gap_w = $signed({10'd0, cfg.gap_penalty});
    if (qbase == prev.base) begin
      sc_w = $signed({10'd0, cfg.match_score});
    end else begin
      sc_w = $signed({{9{cfg.mismatch_score[4]}}, cfg.mismatch_score});
    end
    ix_new = las_pkg::smax(up_h_w, up_ix_w) - gap_w;
    iy_new = las_pkg::smax(h_w, iy_w) - gap_w;
    d_new = $signed({2'b00, prev.diag}) + sc_w;
    h_new = las_pkg::smax(las_pkg::smax(d_new, ix_new), las_pkg::smax(iy_new, 14'sd0));
    if (h_new > las_pkg::H_CLAMP) begin
      h_new = las_pkg::H_CLAMP;
    end
    best_w = $signed({prev.best[12], prev.best});
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      qbase <= load_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      h <= '0;
      iy <= '0;
    end else if (prev.tok && ctl.active) begin
      h <= h_new[11:0];
      iy <= iy_new[12:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg.tok <= 1'b0;
    end else begin
      out_reg.tok <= prev.tok;
    end
    if (prev.tok) begin
      out_reg.base <= prev.base;
      if (ctl.active) begin
        out_reg.up_h <= h_new[11:0];
        out_reg.up_ix <= ix_new[12:0];
        out_reg.diag <= h;
        out_reg.best <= (h_new > best_w) ? h_new[12:0] : prev.best;
      end else begin
        out_reg.up_h <= prev.up_h;
        out_reg.up_ix <= prev.up_ix;
        out_reg.diag <= prev.diag;
        out_reg.best <= prev.best;
      end
    end
  end

  assign next = out_reg;

endmodule
